// File: sv/nta_pkg.sv
// number-to-ascii formatter: shared payload types, format kind codes
// and the nibble-to-ascii helper
// no dependencies
`default_nettype none

package nta_pkg;

  // format kind codes carried on the input beat
  localparam logic [1:0] KIND_DEC      = 2'd0;
  localparam logic [1:0] KIND_HEX_BYTE = 2'd1;
  localparam logic [1:0] KIND_HEX_WORD = 2'd2;

  // fixed field widths
  localparam int unsigned NUMBER_W = 32;
  localparam int unsigned CHAR_W   = 7;

  // ascii constants
  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] ALPHA_OFFSET = 7'd55;   // 'A' - 10
  localparam logic [3:0]        DEC_RADIX    = 4'd10;

  typedef struct packed {
    logic [1:0]          kind;
    logic [NUMBER_W-1:0] number;
  } nta_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } nta_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // take a new number
    logic conv;     // one binary-to-bcd step
    logic finish;   // locate most significant decimal digit
    logic emit;     // push one character into the output register
  } nta_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic conv_done;  // current conversion step is the final one
    logic at_last;    // digit index points at the final character
    logic out_free;   // output register can take a character this cycle
  } nta_sts_t;

  // one nibble to uppercase ascii hex digit
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, nib};
    return (nib < DEC_RADIX) ? (ASCII_ZERO + ext) : (ALPHA_OFFSET + ext);
  endfunction

endpackage

`default_nettype wire

// File: sv/nta_ctrl.sv
// number-to-ascii formatter: controller state machine
// depends on nta_pkg
`default_nettype none

module nta_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        kind_i,
  output logic                   in_ready_o,
  input  wire nta_pkg::nta_sts_t sts_i,
  output nta_pkg::nta_cmd_t      cmd_o
);
  import nta_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // input side is open only between numbers
  assign in_ready_o = (state_q == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (kind_i == KIND_DEC) begin
            state_d = ST_CONV;
          end else if (kind_i inside {KIND_HEX_BYTE, KIND_HEX_WORD}) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.at_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/nta_dp.sv
// number-to-ascii formatter: datapath with shift-add-3 bcd converter,
// digit buffer, digit index and output register
// depends on nta_pkg
`default_nettype none

module nta_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nta_pkg::nta_in_t  in_data_i,
  input  wire nta_pkg::nta_cmd_t cmd_i,
  output nta_pkg::nta_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output nta_pkg::nta_out_t      out_data_o
);
  import nta_pkg::*;

  // formatted bits of the number
  localparam int unsigned VW_EFF = (VALUE_WIDTH < NUMBER_W) ? VALUE_WIDTH : NUMBER_W;
  // decimal digits needed: floor(w * log10 2) + 1
  localparam int unsigned DEC_N  = (VW_EFF * 1233) / 4096 + 1;
  localparam int unsigned HEX_N  = 8;
  localparam int unsigned DIG_N  = (DEC_N > HEX_N) ? DEC_N : HEX_N;
  localparam int unsigned DIG_W  = DIG_N * 4;
  localparam int unsigned IDX_W  = $clog2(DIG_N);
  localparam int unsigned CNT_W  = $clog2(VW_EFF);

  logic [VW_EFF-1:0] bin_q;
  logic [DIG_W-1:0]  dig_q, adj;
  logic [CNT_W-1:0]  bitcnt_q;
  logic [IDX_W-1:0]  idx_q, msd;
  logic [3:0]        cur_nib;
  logic              out_valid_q;
  nta_out_t          out_q;

  // add 3 to every bcd digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < int'(DIG_N); k++) begin
      adj[k*4 +: 4] = (dig_q[k*4 +: 4] >= 4'd5) ? dig_q[k*4 +: 4] + 4'd3
                                                 : dig_q[k*4 +: 4];
    end
  end

  // most significant non-zero decimal digit, digit zero if none
  always_comb begin
    msd = '0;
    for (int k = 0; k < int'(DEC_N); k++) begin
      if (dig_q[k*4 +: 4] != 4'd0) begin
        msd = IDX_W'(k);
      end
    end
  end

  assign cur_nib = dig_q[{idx_q, 2'b00} +: 4];

  // status back to the controller
  assign sts_o.conv_done = (bitcnt_q == CNT_W'(VW_EFF - 1));
  assign sts_o.at_last   = (idx_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // number, digit buffer and index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q    <= in_data_i.number[VW_EFF-1:0];
      bitcnt_q <= '0;
      if (in_data_i.kind == KIND_HEX_BYTE) begin
        dig_q <= DIG_W'(in_data_i.number[7:0]);
        idx_q <= IDX_W'(1);
      end else if (in_data_i.kind == KIND_HEX_WORD) begin
        dig_q <= DIG_W'(in_data_i.number[VW_EFF-1:0]);
        idx_q <= IDX_W'(HEX_N - 1);
      end else begin
        dig_q <= '0;
        idx_q <= '0;
      end
    end else if (cmd_i.conv) begin
      dig_q    <= {adj[DIG_W-2:0], bin_q[VW_EFF-1]};
      bin_q    <= bin_q << 1;
      bitcnt_q <= bitcnt_q + 1'b1;
    end else if (cmd_i.finish) begin
      idx_q <= msd;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.character <= hex_char(cur_nib);
      out_q.last      <= (idx_q == '0);
    end
  end

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a beat never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("character pushed over a pending beat");

  // after the scan the index sits on a non-zero digit or on digit zero
  a_msd_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.finish) |-> (cur_nib != 4'd0 || idx_q == '0))
    else $error("leading zero left in decimal output");

  // only one datapath command at a time
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.load, cmd_i.conv, cmd_i.finish, cmd_i.emit}))
    else $error("conflicting datapath commands");

  // emitted characters are hex digits
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.character >= 7'd48 && out_q.character <= 7'd57) ||
                     (out_q.character >= 7'd65 && out_q.character <= 7'd70)))
    else $error("character outside hex digit range");

endmodule

`default_nettype wire

// File: sv/number_to_ascii_formatter.sv
// number-to-ascii formatter: top level joining controller and datapath
// depends on nta_pkg, nta_ctrl, nta_dp
//
//   port group        direction  payload              per beat
//   in_valid/ready/data  in      kind, number         one number
//   out_valid/ready/data out     character, last      one ascii digit
//
// hex-byte: a load then two characters; hex-word: a load then eight characters.
// decimal: a load, min(VALUE_WIDTH,32) shift-add-3 steps and a digit
// scan, then one character per digit (1 to 10).
// a new number is taken once the final character sits in the output register.
// out_ready low holds the character and pauses digit output; reset empties
// the output register and returns the controller to idle.
`default_nettype none

module number_to_ascii_formatter #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire nta_pkg::nta_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output nta_pkg::nta_out_t     out_data_o
);
  import nta_pkg::*;

  nta_cmd_t cmd;
  nta_sts_t sts;

  // sequencing
  nta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_data_i.kind),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // conversion and character output
  nta_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
